// File: sv/i2c_eeprom_block_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C EEPROM block sequencer assertion macros
// Shared concurrent assertion forms for the sequencer modules.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_BLOCK_SEQUENCER_MACROS_SVH
`define I2C_EEPROM_BLOCK_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define I2CEBS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define I2CEBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/i2cebs_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM block sequencer package
// Codes, widths and transaction types shared by the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cebs_pkg;

   // Default store depth
   localparam int BUF_DEPTH_DEF = 64;

   // Operation codes of an input transaction
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_EVENT = 2'd3;

   // Bus command codes
   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_START    = 3'd1;
   localparam logic [2:0] CMD_SEND     = 3'd2;
   localparam logic [2:0] CMD_RSTART   = 3'd3;
   localparam logic [2:0] CMD_ENTER_RX = 3'd4;
   localparam logic [2:0] CMD_RECEIVE  = 3'd5;
   localparam logic [2:0] CMD_STOP     = 3'd6;

   // Sequencer phases
   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_HIGH   = 4'd1;
   localparam logic [3:0] PH_LOW    = 4'd2;
   localparam logic [3:0] PH_WDATA  = 4'd3;
   localparam logic [3:0] PH_STOP   = 4'd4;
   localparam logic [3:0] PH_RSTART = 4'd5;
   localparam logic [3:0] PH_DUMMY  = 4'd6;
   localparam logic [3:0] PH_READ   = 4'd7;

   // Reset value of the device address register
   localparam logic [7:0] DEV_ADDR_RESET = 8'hA0;

   // Input transaction
   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  load_index;
      logic [7:0]  load_data;
      logic [15:0] mem_address;
      logic [6:0]  length;
      logic [7:0]  rx_data;
      logic        rx_nack;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [5:0] rx_index;
      logic [7:0] rx_byte;
      logic       ack_next;
      logic       done_res;
      logic       busy_res;
   } rsp_type;

   // Store write request
   typedef struct packed {
      logic       en;
      logic [5:0] index;
      logic [7:0] data;
   } store_wr_type;

endpackage

// File: sv/i2cebs_store.sv
// ----------------------------------------------------------------------------
// I2C EEPROM block sequencer write store
// Byte memory with one write port and a registered read that always holds
// the entry at the sequencer's data index, write data forwarded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cebs_store
   import i2cebs_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input  logic         clock,
   input  store_wr_type wr,
   input  logic [6:0]   rd_index,
   output logic [7:0]   rd_data
);

   localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   logic [7:0]        mem [BUF_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign wr_addr = ADDR_W'(wr.index);
   assign rd_addr = ADDR_W'(rd_index);
   assign rd_data = rd_data_ff;

   // Write the memory
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   // Refresh the read register every cycle, forward a same-cycle write
   always_ff @(posedge clock) begin
      if (wr.en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: sv/i2cebs_ctrl.sv
// ----------------------------------------------------------------------------
// I2C EEPROM block sequencer control
// Holds the transfer state and works out the bus command for one transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "i2c_eeprom_block_sequencer_macros.svh"

module i2cebs_ctrl
   import i2cebs_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_type      req,
   input  logic [7:0]   dev_addr,
   input  logic [7:0]   store_data,
   output store_wr_type store_wr,
   output logic [6:0]   data_index_next,
   output rsp_type      rsp
);

   localparam logic [8:0] DEPTH_9 = 9'(BUF_DEPTH);

   logic [3:0]  phase_ff, phase_in;
   logic        is_read_ff, is_read_in;
   logic [6:0]  data_index_ff, data_index_in;
   logic [6:0]  remaining_ff, remaining_in;
   logic [15:0] target_ff, target_in;
   logic [6:0]  len_clamped;
   logic [6:0]  remaining_dec;
   logic        index_in_range;

   // Clamp the requested length to 1..BUF_DEPTH
   always_comb begin
      if (req.length == 7'd0) begin
         len_clamped = 7'd1;
      end else if ({2'b00, req.length} > DEPTH_9) begin
         len_clamped = 7'(BUF_DEPTH);
      end else begin
         len_clamped = req.length;
      end
   end

   assign remaining_dec  = (remaining_ff != 7'd0) ? (remaining_ff - 7'd1) : 7'd0;
   assign index_in_range = ({2'b00, data_index_ff} < DEPTH_9);

   // Store write for a load transaction
   always_comb begin
      store_wr.en    = step && (req.func == FUNC_LOAD) && ({3'b000, req.load_index} < DEPTH_9);
      store_wr.index = req.load_index;
      store_wr.data  = req.load_data;
   end

   // Next state and result
   always_comb begin
      phase_in      = phase_ff;
      is_read_in    = is_read_ff;
      data_index_in = data_index_ff;
      remaining_in  = remaining_ff;
      target_in     = target_ff;
      rsp           = '0;
      case (req.func)
         FUNC_LOAD: begin
         end
         FUNC_WRITE, FUNC_READ: begin
            is_read_in    = (req.func == FUNC_READ);
            target_in     = req.mem_address;
            remaining_in  = len_clamped;
            data_index_in = 7'd0;
            phase_in      = PH_HIGH;
            rsp.cmd       = CMD_START;
            rsp.tx_byte   = dev_addr & 8'hFE;
         end
         default: begin
            case (phase_ff)
               PH_IDLE: begin
               end
               PH_HIGH: begin
                  rsp.cmd     = CMD_SEND;
                  rsp.tx_byte = target_ff[15:8];
                  phase_in    = PH_LOW;
               end
               PH_LOW: begin
                  rsp.cmd       = CMD_SEND;
                  rsp.tx_byte   = target_ff[7:0];
                  data_index_in = 7'd0;
                  phase_in      = is_read_ff ? PH_RSTART : PH_WDATA;
               end
               PH_WDATA: begin
                  rsp.cmd       = CMD_SEND;
                  rsp.tx_byte   = index_in_range ? store_data : 8'h00;
                  data_index_in = data_index_ff + 7'd1;
                  remaining_in  = remaining_dec;
                  if (remaining_dec == 7'd0) begin
                     phase_in = PH_STOP;
                  end
               end
               PH_STOP: begin
                  rsp.cmd      = CMD_STOP;
                  rsp.done_res = 1'b1;
                  phase_in     = PH_IDLE;
               end
               PH_RSTART: begin
                  rsp.cmd     = CMD_RSTART;
                  rsp.tx_byte = dev_addr | 8'h01;
                  phase_in    = PH_DUMMY;
               end
               PH_DUMMY: begin
                  rsp.cmd      = CMD_ENTER_RX;
                  rsp.ack_next = (remaining_ff > 7'd1);
                  phase_in     = PH_READ;
               end
               PH_READ: begin
                  rsp.rx_valid = 1'b1;
                  rsp.rx_index = data_index_ff[5:0];
                  rsp.rx_byte  = req.rx_data;
                  remaining_in = remaining_dec;
                  if (req.rx_nack || (remaining_ff <= 7'd1)) begin
                     // Last byte or nack: deliver and stop together
                     rsp.cmd      = CMD_STOP;
                     rsp.done_res = 1'b1;
                     phase_in     = PH_IDLE;
                  end else begin
                     data_index_in = data_index_ff + 7'd1;
                     rsp.cmd       = CMD_RECEIVE;
                     rsp.ack_next  = (remaining_dec > 7'd1);
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      endcase
      rsp.busy_res = (phase_in != PH_IDLE);
   end

   // Hand the store the index it must hold next cycle
   assign data_index_next = step ? data_index_in : data_index_ff;

   // Advance the state on each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         is_read_ff    <= 1'b0;
         data_index_ff <= 7'd0;
         remaining_ff  <= 7'd0;
         target_ff     <= 16'd0;
      end else if (step) begin
         phase_ff      <= phase_in;
         is_read_ff    <= is_read_in;
         data_index_ff <= data_index_in;
         remaining_ff  <= remaining_in;
         target_ff     <= target_in;
      end
   end

   `I2CEBS_ASSERT_IMPLY(a_done_is_stop, clock, reset, step && rsp.done_res, rsp.cmd == CMD_STOP, "done without stop")
   `I2CEBS_ASSERT_NEXT(a_done_goes_idle, clock, reset, step && rsp.done_res, phase_ff == PH_IDLE, "phase not idle after stop")
   `I2CEBS_ASSERT_IMPLY(a_rx_only_in_read, clock, reset, step && rsp.rx_valid, (rsp.cmd == CMD_STOP) || (rsp.cmd == CMD_RECEIVE), "received byte outside read")
   `I2CEBS_ASSERT_NEXT(a_begin_to_high, clock, reset, step && (req.func == FUNC_WRITE || req.func == FUNC_READ), phase_ff == PH_HIGH, "begin did not enter address phase")

endmodule

// File: sv/i2c_eeprom_block_sequencer.sv
// ----------------------------------------------------------------------------
// I2C EEPROM block sequencer
// Flow: a transaction accepted into the input register is processed into the
// result register unless a waiting result there is stalled. Throughput: one
// transaction per cycle while results are not stalled; the state update and the
// prefetched store byte resolve in one pass between input and result registers.
// Reset: synchronous active high; clears phase, counters and valids, device
// address returns to 0xA0; the write store contents are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_eeprom_block_sequencer
   import i2cebs_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_load_index,
   input  logic [7:0]  req_load_data,
   input  logic [15:0] req_mem_address,
   input  logic [6:0]  req_length,
   input  logic [7:0]  req_rx_data,
   input  logic        req_rx_nack,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_cmd,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_rx_valid,
   output logic [5:0]  rsp_rx_index,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_next,
   output logic        rsp_done_res,
   output logic        rsp_busy_res,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic         in_valid_ff, in_valid_in;
   req_type      in_req_ff;
   req_type      req_bus;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff;
   rsp_type      rsp_comb;
   logic [7:0]   dev_addr_ff;
   logic         accept;
   logic         step;
   store_wr_type store_wr;
   logic [6:0]   data_index_next;
   logic [7:0]   store_data;

   assign req_bus = '{func: req_func, load_index: req_load_index,
                      load_data: req_load_data, mem_address: req_mem_address,
                      length: req_length, rx_data: req_rx_data,
                      rx_nack: req_rx_nack};

   // Process the held transaction when the result register frees up
   assign step        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !step;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   // Hold the input transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= req_bus;
      end
   end

   // Hold the result transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_comb;
      end
   end

   // Device address register
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEV_ADDR_RESET;
      end else if (csr_wr_en) begin
         dev_addr_ff <= csr_wr_data;
      end
   end

   i2cebs_store #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_store (
      .clock    (clock),
      .wr       (store_wr),
      .rd_index (data_index_next),
      .rd_data  (store_data)
   );

   i2cebs_ctrl #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .req             (in_req_ff),
      .dev_addr        (dev_addr_ff),
      .store_data      (store_data),
      .store_wr        (store_wr),
      .data_index_next (data_index_next),
      .rsp             (rsp_comb)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cmd      = rsp_ff.cmd;
   assign rsp_tx_byte  = rsp_ff.tx_byte;
   assign rsp_rx_valid = rsp_ff.rx_valid;
   assign rsp_rx_index = rsp_ff.rx_index;
   assign rsp_rx_byte  = rsp_ff.rx_byte;
   assign rsp_ack_next = rsp_ff.ack_next;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_busy_res = rsp_ff.busy_res;

endmodule

// File: tb/sv/bus_command_checker.sv
// ----------------------------------------------------------------------------
// Bus command checker for the I2C EEPROM block sequencer
// Watches the request, result and register ports, keeps its own model of the
// sequencer and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_command_checker
   import i2cebs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_load_index,
   input  logic [7:0]  req_load_data,
   input  logic [15:0] req_mem_address,
   input  logic [6:0]  req_length,
   input  logic [7:0]  req_rx_data,
   input  logic        req_rx_nack,
   // Result channel
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_cmd,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_rx_valid,
   input  logic [5:0]  rsp_rx_index,
   input  logic [7:0]  rsp_rx_byte,
   input  logic        rsp_ack_next,
   input  logic        rsp_done_res,
   input  logic        rsp_busy_res,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   // Status for the top
   output int          fail_count,
   output int          expected_left,
   output int          checked_count,
   output int          stop_count,
   output int          rx_byte_count
);

   localparam int STORE_DEPTH = BUF_DEPTH_DEF;

   // Mirror of the sequencer state
   logic [7:0]  dev_addr_byte;
   logic [3:0]  seq_phase;
   logic        seq_is_read;
   logic [6:0]  byte_pos;
   logic [6:0]  bytes_left;
   logic [15:0] target_addr;
   logic [7:0]  store_mirror [STORE_DEPTH];

   // Bus commands predicted but not yet seen on the result port
   rsp_type pending_commands [$];

   // Advance the mirror by one transaction and return the command it issues
   function automatic rsp_type next_bus_command(input req_type t);
      rsp_type     r;
      int unsigned len;
      bit          issue_stop;
      r = '0;
      issue_stop = 1'b0;
      case (t.func)
         FUNC_LOAD: begin
            store_mirror[t.load_index] = t.load_data;
         end
         FUNC_WRITE, FUNC_READ: begin
            // clamp the length into 1..depth, then open with the device byte
            len = 32'(t.length);
            if (len < 1) len = 1;
            if (len > STORE_DEPTH) len = STORE_DEPTH;
            seq_is_read = (t.func == FUNC_READ);
            target_addr = t.mem_address;
            bytes_left = 7'(len);
            byte_pos = '0;
            seq_phase = PH_HIGH;
            r.cmd = CMD_START;
            r.tx_byte = dev_addr_byte & 8'hFE;
         end
         default: begin
            case (seq_phase)
               PH_HIGH: begin
                  r.cmd = CMD_SEND;
                  r.tx_byte = target_addr[15:8];
                  seq_phase = PH_LOW;
               end
               PH_LOW: begin
                  r.cmd = CMD_SEND;
                  r.tx_byte = target_addr[7:0];
                  byte_pos = '0;
                  seq_phase = seq_is_read ? PH_RSTART : PH_WDATA;
               end
               PH_WDATA: begin
                  // nack is ignored while writing
                  r.cmd = CMD_SEND;
                  r.tx_byte = (byte_pos < 7'(STORE_DEPTH)) ? store_mirror[byte_pos[5:0]]
                                                           : 8'h00;
                  byte_pos++;
                  if (bytes_left != 0) bytes_left--;
                  if (bytes_left == 0) seq_phase = PH_STOP;
               end
               PH_STOP: begin
                  issue_stop = 1'b1;
               end
               PH_RSTART: begin
                  r.cmd = CMD_RSTART;
                  r.tx_byte = dev_addr_byte | 8'h01;
                  seq_phase = PH_DUMMY;
               end
               PH_DUMMY: begin
                  r.cmd = CMD_ENTER_RX;
                  r.ack_next = (bytes_left > 1);
                  seq_phase = PH_READ;
               end
               PH_READ: begin
                  // deliver the byte; a nack or the last byte closes with a stop
                  r.rx_valid = 1'b1;
                  r.rx_index = byte_pos[5:0];
                  r.rx_byte = t.rx_data;
                  if (t.rx_nack || bytes_left <= 1) begin
                     if (bytes_left != 0) bytes_left--;
                     issue_stop = 1'b1;
                  end else begin
                     byte_pos++;
                     bytes_left--;
                     r.cmd = CMD_RECEIVE;
                     r.ack_next = (bytes_left > 1);
                  end
               end
               default: begin
                  seq_phase = PH_IDLE;
               end
            endcase
         end
      endcase
      if (issue_stop) begin
         r.cmd = CMD_STOP;
         r.done_res = 1'b1;
         seq_phase = PH_IDLE;
      end
      r.busy_res = (seq_phase != PH_IDLE);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Sample all three ports on the rising edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         dev_addr_byte = DEV_ADDR_RESET;
         seq_phase = PH_IDLE;
         seq_is_read = 1'b0;
         byte_pos = '0;
         bytes_left = '0;
         target_addr = '0;
         pending_commands.delete();
      end else begin
         if (csr_wr_en) dev_addr_byte = csr_wr_data;

         // retire the oldest prediction against the accepted result
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_cmd, rsp_tx_byte, rsp_rx_valid, rsp_rx_index, rsp_rx_byte,
                   rsp_ack_next, rsp_done_res, rsp_busy_res};
            if (pending_commands.size() == 0) begin
               $error("result with no transaction waiting: cmd %0d", rsp_cmd);
               fail_count++;
            end else begin
               want = pending_commands.pop_front();
               check_field("cmd", 16'(want.cmd), 16'(got.cmd));
               check_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
               check_field("rx_valid", 16'(want.rx_valid), 16'(got.rx_valid));
               check_field("rx_index", 16'(want.rx_index), 16'(got.rx_index));
               check_field("rx_byte", 16'(want.rx_byte), 16'(got.rx_byte));
               check_field("ack_next", 16'(want.ack_next), 16'(got.ack_next));
               check_field("done_res", 16'(want.done_res), 16'(got.done_res));
               check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
               checked_count++;
               if (want.done_res) stop_count++;
               if (want.rx_valid) rx_byte_count++;
            end
         end

         // predict the command for each accepted transaction
         if (req_valid && !req_stall) begin
            pending_commands.push_back(next_bus_command({req_func, req_load_index,
               req_load_data, req_mem_address, req_length, req_rx_data, req_rx_nack}));
         end
      end
      expected_left <= pending_commands.size();
   end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// I2C EEPROM block sequencer testbench
// Drives directed and random load, begin and byte-complete transactions with
// random idling on both channels, steps the device address register through
// several values, and takes the verdict from the bus command checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import i2cebs_pkg::*;

   localparam int STORE_DEPTH = BUF_DEPTH_DEF;
   localparam int PHASE_ITEMS = 196;
   localparam int LONG_HOLD   = 200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_item;
   logic [1:0]  req_func;
   logic [5:0]  req_load_index;
   logic [7:0]  req_load_data;
   logic [15:0] req_mem_address;
   logic [6:0]  req_length;
   logic [7:0]  req_rx_data;
   logic        req_rx_nack;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_cmd;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_rx_valid;
   logic [5:0]  rsp_rx_index;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_ack_next;
   logic        rsp_done_res;
   logic        rsp_busy_res;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   int          fail_count;
   int          expected_left;
   int          checked_count;
   int          stop_count;
   int          rx_byte_count;

   int          items_sent;
   int          settings_used;
   bit          no_gaps;
   bit          hold_request;
   bit          store_loaded [STORE_DEPTH];

   assign req_func        = req_item.func;
   assign req_load_index  = req_item.load_index;
   assign req_load_data   = req_item.load_data;
   assign req_mem_address = req_item.mem_address;
   assign req_length      = req_item.length;
   assign req_rx_data     = req_item.rx_data;
   assign req_rx_nack     = req_item.rx_nack;

   i2c_eeprom_block_sequencer u_top (.*);

   bus_command_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Fill every field at random, then fix the operation
   function automatic req_type random_item(input logic [1:0] op);
      req_type t;
      t = req_type'(48'({$urandom(), $urandom()}));
      t.func = op;
      return t;
   endfunction

   // Offer one transaction after a random gap and hold it until taken
   task automatic send_item(input req_type t);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_byte(input logic [5:0] idx, input logic [7:0] data);
      req_type t;
      t = random_item(FUNC_LOAD);
      t.load_index = idx;
      t.load_data = data;
      send_item(t);
      store_loaded[idx] = 1'b1;
   endtask

   task automatic begin_transfer(input bit rd, input logic [15:0] addr,
                                 input logic [6:0] len);
      req_type t;
      t = random_item(rd ? FUNC_READ : FUNC_WRITE);
      t.mem_address = addr;
      t.length = len;
      send_item(t);
   endtask

   task automatic bus_event(input logic [7:0] data, input logic nack);
      req_type t;
      t = random_item(FUNC_EVENT);
      t.rx_data = data;
      t.rx_nack = nack;
      send_item(t);
   endtask

   // One block transfer with random content, sometimes cut short
   task automatic run_transfer();
      bit         rd;
      logic [6:0] len;
      int         eff;
      int         n_ev;
      int         cut;
      int         i;
      int         r;
      logic       nack;
      rd = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 65) len = 7'($urandom_range(1, 8));
      else if (r < 85) len = 7'($urandom_range(9, 63));
      else if (r < 92) len = 7'(STORE_DEPTH);
      else if (r < 96) len = 7'd0;
      else len = 7'($urandom_range(65, 127));
      eff = (len == 0) ? 1 : ((len > STORE_DEPTH) ? STORE_DEPTH : len);

      // a write only ever sends store entries that hold data
      if (!rd) begin
         for (i = 0; i < eff; i++) begin
            if (!store_loaded[i]) load_byte(6'(i), 8'($urandom_range(0, 255)));
         end
      end
      begin_transfer(rd, 16'($urandom_range(0, 65535)), len);

      n_ev = rd ? 4 + eff : 3 + eff;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_ev - 1) : n_ev;
      for (i = 0; i < cut; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            load_byte(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
         end
         if (rd && i >= 4) begin
            nack = (i == n_ev - 1) ? 1'($urandom_range(0, 1))
                                   : ($urandom_range(0, 19) == 0);
         end else begin
            nack = ($urandom_range(0, 3) == 0);
         end
         bus_event(8'($urandom_range(0, 255)), nack);
         // a nack on a received byte ends the read
         if (rd && i >= 4 && nack) break;
      end
   endtask

   // Stop offering and wait until every result has been taken
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   task automatic write_device_byte(input logic [7:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Result side: random stall per result, one long hold-off on request
   initial begin : result_sink
      int hold;
      rsp_stall <= 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = hold_request ? LONG_HOLD : (no_gaps ? 0 : $urandom_range(0, 17));
         hold_request = 1'b0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int         p;
      int         phase_end;
      logic [7:0] dev_byte;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      settings_used = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // event with no transfer running
      bus_event(8'hFF, 1'b1);
      load_byte(6'd0, 8'h00);
      load_byte(6'd1, 8'hFF);
      load_byte(6'd63, 8'hA5);
      // two-byte write to the top address, nack on data ignored
      begin_transfer(1'b0, 16'hFFFF, 7'd2);
      bus_event(8'h00, 1'b0);
      bus_event(8'hFF, 1'b0);
      bus_event(8'h3C, 1'b1);
      bus_event(8'hC3, 1'b0);
      bus_event(8'h00, 1'b0);
      // zero length clamps to one byte; last byte comes with the stop
      begin_transfer(1'b1, 16'h0000, 7'd0);
      bus_event(8'h12, 1'b0);
      bus_event(8'h34, 1'b0);
      bus_event(8'h56, 1'b0);
      bus_event(8'h78, 1'b0);
      bus_event(8'hFF, 1'b0);
      // oversize length clamps to the depth; nack ends the read early
      begin_transfer(1'b1, 16'h8001, 7'd127);
      bus_event(8'h00, 1'b1);
      bus_event(8'h00, 1'b0);
      bus_event(8'h00, 1'b0);
      bus_event(8'h00, 1'b0);
      bus_event(8'h00, 1'b0);
      bus_event(8'h5A, 1'b1);
      // begin a read while a write is still running
      begin_transfer(1'b0, 16'h00FF, 7'd1);
      bus_event(8'h81, 1'b0);
      begin_transfer(1'b1, 16'h7F00, 7'd3);

      // random phases under a series of device address bytes, the reset value first and last
      for (p = 0; p < 6; p++) begin
         case (p)
            1: dev_byte = 8'h00;
            2: dev_byte = 8'hFE;
            3: dev_byte = 8'h57;
            4: dev_byte = 8'($urandom_range(0, 254));
            default: dev_byte = DEV_ADDR_RESET;
         endcase
         if (p > 0) write_device_byte(dev_byte);
         if (p == 3) hold_request = 1'b1;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            no_gaps = (p == 3 && items_sent < phase_end - PHASE_ITEMS / 2)
                      || ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 8) begin
               run_transfer();
            end else if ($urandom_range(0, 1) == 0) begin
               load_byte(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
            end else begin
               bus_event(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         end
      end
      no_gaps = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      $display("Drove %0d transactions under %0d device address settings; %0d results checked.",
               items_sent, settings_used, checked_count);
      $display("Transfers closed by a stop: %0d; received bytes delivered: %0d.",
               stop_count, rx_byte_count);
      if (expected_left != 0) $error("%0d results never arrived", expected_left);
      if (fail_count == 0 && expected_left == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #10_000_000;
      $error("run timed out");
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/i2cebs_pkg.sv
sv/i2cebs_store.sv
sv/i2cebs_ctrl.sv
sv/i2c_eeprom_block_sequencer.sv
tb/sv/bus_command_checker.sv
tb/sv/testbench.sv
